@@ design/kslt_pkg.sv @@
package kslt_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KEY_W       = 64;
    localparam int PAYLOAD_W   = 64;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_CNT_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic             rotate;
        logic             compact;
        logic [IDX_W-1:0] pos;
    } t_cell_ctrl;

endpackage

@@ design/kslt_cell.sv @@
module kslt_cell
    import kslt_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [IDX_W-1:0] i_index,
    input  t_entry           i_next,
    output t_entry           o_entry
);

    t_entry r_entry;
    logic   w_take;

    // A rotation moves every cell; a compaction moves only the cells at or above the removed slot.
    assign w_take = i_ctrl.rotate | (i_ctrl.compact & (i_index >= i_ctrl.pos));

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ design/keyed_sequential_list_table_unit.sv @@
// Insert and remove run ST_IDLE, ST_SCAN, ST_REPLY; a removal that finds its key adds ST_SHIFT.
// One request at a time; the ring makes one full turn per insert, remove or non-empty list.
// A list emits one held entry per step of the rotation and stalls with the output side.
// Reset clears the entry count and the control state; the cell contents are not reset.
module keyed_sequential_list_table_unit
    import kslt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [127:0]  i_s_tdata,  // key[63:0], payload[127:64]
    input  logic [1:0]    i_s_tuser,  // func[1:0]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [143:0]  o_m_tdata,  // status[1:0], entry_count[8:2], out_key[72:9],
                                      // out_payload[136:73], zero fill[143:137]
    output logic [0:0]    o_m_tuser,  // entry_valid[0]
    output logic          o_m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_REPLY = 4'b1000
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ENTRY_CNT_W-1:0] entry_count;
        logic [KEY_W-1:0]       key;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   entry_valid;
        logic                   last;
    } t_result;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_step, n_step;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [FUNC_W-1:0]   r_func, n_func;
    t_entry              r_req, n_req;
    logic                r_hit, n_hit;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    t_entry     w_cell [CAPACITY];
    t_entry     w_tail_next;
    t_cell_ctrl w_ctrl;
    logic       w_out_free;
    logic       w_advance;
    logic       w_rotate;
    logic       w_inject;
    logic       w_head_hit;
    logic       w_scan_end;
    logic       w_accept;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);

    assign w_advance  = (r_func != FUNC_LIST) || (r_step >= r_count) || w_out_free;
    assign w_rotate   = (r_state == ST_SCAN) && w_advance;
    assign w_inject   = w_rotate && (r_func == FUNC_INSERT) && (r_step == r_count) && !r_hit;
    assign w_head_hit = w_rotate && (r_func != FUNC_LIST) && (r_step < r_count)
                        && (w_cell[0].key == r_req.key);
    assign w_scan_end = w_rotate && (r_step == CNT_W'(CAPACITY - 1));

    assign w_ctrl.rotate  = w_rotate;
    assign w_ctrl.compact = (r_state == ST_SHIFT);
    assign w_ctrl.pos     = r_pos;

    assign w_tail_next = w_inject ? r_req : w_cell[0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        kslt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (IDX_W'(g)),
            .i_next  ((g == CAPACITY - 1) ? w_tail_next : w_cell[(g + 1) % CAPACITY]),
            .o_entry (w_cell[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_count     = r_count;
        n_func      = r_func;
        n_req       = r_req;
        n_hit       = r_hit;
        n_pos       = r_pos;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out       = r_out;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_func        = i_s_tuser;
                    n_req.key     = i_s_tdata[63:0];
                    n_req.payload = i_s_tdata[127:64];
                    n_hit         = 1'b0;
                    n_step        = '0;
                    n_status      = STATUS_OK;
                    if ((i_s_tuser == FUNC_INSERT) || (i_s_tuser == FUNC_REMOVE)
                        || ((i_s_tuser == FUNC_LIST) && (r_count != '0))) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_REPLY;
                    end
                end
            end
            ST_SCAN: begin
                if (w_rotate) begin
                    n_step = r_step + CNT_W'(1);
                    if (w_head_hit && !r_hit) begin
                        n_hit = 1'b1;
                        n_pos = r_step[IDX_W-1:0];
                    end
                    if ((r_func == FUNC_LIST) && (r_step < r_count)) begin
                        n_out_valid       = 1'b1;
                        n_out.status      = STATUS_OK;
                        n_out.entry_count = ENTRY_CNT_W'(r_count);
                        n_out.key         = w_cell[0].key;
                        n_out.payload     = w_cell[0].payload;
                        n_out.entry_valid = 1'b1;
                        n_out.last        = (r_step == r_count - CNT_W'(1));
                    end
                end
                if (w_scan_end) begin
                    case (r_func)
                        FUNC_INSERT: begin
                            n_state = ST_REPLY;
                            if (r_hit || w_head_hit) begin
                                n_status = STATUS_DUPLICATE;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = STATUS_FULL;
                            end else begin
                                n_status = STATUS_OK;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        FUNC_REMOVE: begin
                            if (r_hit || w_head_hit) begin
                                n_state = ST_SHIFT;
                            end else begin
                                n_status = STATUS_NOT_FOUND;
                                n_state  = ST_REPLY;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                n_count  = r_count - CNT_W'(1);
                n_status = STATUS_OK;
                n_state  = ST_REPLY;
            end
            ST_REPLY: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.entry_count = ENTRY_CNT_W'(r_count);
                    n_out.key         = '0;
                    n_out.payload     = '0;
                    n_out.entry_valid = 1'b0;
                    n_out.last        = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_hit       <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_req    <= n_req;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_s_tready   = (r_state == ST_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {7'd0, r_out.payload, r_out.key, r_out.entry_count, r_out.status};
    assign o_m_tuser[0] = r_out.entry_valid;
    assign o_m_tlast    = r_out.last;

endmodule

@@ dv/keyed_sequential_list_table_unit_tb.sv @@
`timescale 1ns / 1ps

module keyed_sequential_list_table_unit_tb;
    import kslt_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
    localparam int N_DIRECTED    = 19;
    localparam int POOL_SIZE     = 8;

    localparam logic [KEY_W-1:0] KEY_ONES  = '1;
    localparam logic [KEY_W-1:0] KEY_ALPHA = 64'h414C_5048_4100_0000;
    localparam logic [KEY_W-1:0] KEY_BRAVO = 64'h4252_4156_4F00_0000;
    localparam logic [KEY_W-1:0] KEY_EDGES = 64'h8000_0000_0000_0001;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ENTRY_CNT_W-1:0] count;
        logic [KEY_W-1:0]       key;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   valid;
        logic                   last;
    } t_table_result;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [KEY_W-1:0]       key;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   typed;
        logic [STATUS_W-1:0]    status;
        logic [ENTRY_CNT_W-1:0] count;
    } t_table_request;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    logic [KEY_W-1:0]     held_keys [CAPACITY];
    logic [PAYLOAD_W-1:0] held_pays [CAPACITY];
    int                   held_count;
    logic [KEY_W-1:0]     key_pool [POOL_SIZE];
    t_table_result        awaited_results [$];

    int src_idle_pct;
    int sink_idle_pct;
    bit hold_req;
    int error_count;
    int results_checked;
    int peak_count;
    int stall_cycles;
    int requests_by_func [4];

    t_table_request directed_rows [N_DIRECTED] = '{
        '{FUNC_LIST,   64'h0,     64'h0,                 1'b1, STATUS_OK,        7'd0},
        '{FUNC_REMOVE, 64'h0,     64'h0,                 1'b1, STATUS_NOT_FOUND, 7'd0},
        '{FUNC_UNUSED, KEY_ONES,  '1,                    1'b1, STATUS_OK,        7'd0},
        '{FUNC_INSERT, 64'h0,     64'h0,                 1'b1, STATUS_OK,        7'd1},
        '{FUNC_INSERT, KEY_ONES,  '1,                    1'b1, STATUS_OK,        7'd2},
        '{FUNC_INSERT, 64'h0,     64'h5555_5555_5555_5555, 1'b1, STATUS_DUPLICATE, 7'd2},
        '{FUNC_INSERT, KEY_ALPHA, 64'h0123_4567_89AB_CDEF, 1'b1, STATUS_OK,        7'd3},
        '{FUNC_INSERT, KEY_BRAVO, 64'hFEDC_BA98_7654_3210, 1'b1, STATUS_OK,        7'd4},
        '{FUNC_INSERT, KEY_EDGES, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, STATUS_OK,        7'd5},
        '{FUNC_LIST,   64'h0,     64'h0,                 1'b0, STATUS_OK,        7'd0},
        '{FUNC_REMOVE, 64'h0,     64'h0,                 1'b1, STATUS_OK,        7'd4},
        '{FUNC_REMOVE, KEY_ALPHA, 64'h0,                 1'b1, STATUS_OK,        7'd3},
        '{FUNC_REMOVE, KEY_EDGES, 64'h0,                 1'b1, STATUS_OK,        7'd2},
        '{FUNC_REMOVE, KEY_ALPHA, 64'h0,                 1'b1, STATUS_NOT_FOUND, 7'd2},
        '{FUNC_LIST,   KEY_ONES,  '1,                    1'b0, STATUS_OK,        7'd0},
        '{FUNC_UNUSED, KEY_ALPHA, 64'h0,                 1'b1, STATUS_OK,        7'd2},
        '{FUNC_REMOVE, KEY_BRAVO, '1,                    1'b1, STATUS_OK,        7'd1},
        '{FUNC_REMOVE, KEY_ONES,  64'h0,                 1'b1, STATUS_OK,        7'd0},
        '{FUNC_LIST,   64'h0,     64'h0,                 1'b1, STATUS_OK,        7'd0}
    };

    keyed_sequential_list_table_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void queue_result(input logic [STATUS_W-1:0] status,
                                         input logic [KEY_W-1:0] key,
                                         input logic [PAYLOAD_W-1:0] payload,
                                         input logic valid, input logic last);
        t_table_result res;
        res.status  = status;
        res.count   = ENTRY_CNT_W'(held_count);
        res.key     = key;
        res.payload = payload;
        res.valid   = valid;
        res.last    = last;
        awaited_results.push_back(res);
    endfunction

    function automatic void apply_table_op(input logic [FUNC_W-1:0] func,
                                           input logic [KEY_W-1:0] key,
                                           input logic [PAYLOAD_W-1:0] payload);
        int pos;
        int i;
        pos = held_count;
        for (i = held_count - 1; i >= 0; i--) begin
            if (held_keys[i] == key) begin
                pos = i;
            end
        end
        case (func)
            FUNC_INSERT: begin
                if (pos < held_count) begin
                    queue_result(STATUS_DUPLICATE, '0, '0, 1'b0, 1'b1);
                end else if (held_count >= CAPACITY) begin
                    queue_result(STATUS_FULL, '0, '0, 1'b0, 1'b1);
                end else begin
                    held_keys[held_count] = key;
                    held_pays[held_count] = payload;
                    held_count++;
                    queue_result(STATUS_OK, '0, '0, 1'b0, 1'b1);
                end
            end
            FUNC_REMOVE: begin
                if (pos >= held_count) begin
                    queue_result(STATUS_NOT_FOUND, '0, '0, 1'b0, 1'b1);
                end else begin
                    for (i = pos + 1; i < held_count; i++) begin
                        held_keys[i-1] = held_keys[i];
                        held_pays[i-1] = held_pays[i];
                    end
                    held_count--;
                    queue_result(STATUS_OK, '0, '0, 1'b0, 1'b1);
                end
            end
            FUNC_LIST: begin
                if (held_count == 0) begin
                    queue_result(STATUS_OK, '0, '0, 1'b0, 1'b1);
                end
                for (i = 0; i < held_count; i++) begin
                    queue_result(STATUS_OK, held_keys[i], held_pays[i], 1'b1,
                                 i + 1 == held_count);
                end
            end
            default: begin
                queue_result(STATUS_OK, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input int held_pct, input int pool_pct);
        int r;
        r = $urandom_range(99);
        if (r < held_pct && held_count > 0) begin
            return held_keys[$urandom_range(held_count - 1)];
        end else if (r < held_pct + pool_pct) begin
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return {$urandom, $urandom};
    endfunction

    function automatic t_table_request draw_request();
        t_table_request req;
        int r;
        req = '0;
        req.payload = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 40) begin
            req.func = FUNC_INSERT;
            req.key  = pick_key(20, 15);
        end else if (r < 73) begin
            req.func = FUNC_REMOVE;
            req.key  = pick_key(65, 20);
        end else if (r < 93) begin
            req.func = FUNC_LIST;
            req.key  = {$urandom, $urandom};
        end else begin
            req.func = FUNC_UNUSED;
            req.key  = pick_key(30, 30);
        end
        return req;
    endfunction

    function automatic t_table_request fresh_insert();
        t_table_request req;
        req = '0;
        req.func    = FUNC_INSERT;
        req.key     = {$urandom, $urandom};
        req.payload = {$urandom, $urandom};
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 50) begin
            $display("MISMATCH at %0t ns: %s got %0h expected %0h", $time, what, got, want);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input t_table_request req);
        t_table_result typed_res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req.payload, req.key};
        s_tuser  <= req.func;
        do @(posedge i_clk); while (!s_tready);
        apply_table_op(req.func, req.key, req.payload);
        if (req.typed) begin
            typed_res = '{req.status, req.count, '0, '0, 1'b0, 1'b1};
            void'(awaited_results.pop_back());
            awaited_results.push_back(typed_res);
        end
        requests_by_func[req.func]++;
        if (held_count > peak_count) begin
            peak_count = held_count;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_request(draw_request());
    endtask

    always @(posedge i_clk) begin : result_check
        t_table_result got;
        t_table_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status  = m_tdata[1:0];
            got.count   = m_tdata[8:2];
            got.key     = m_tdata[72:9];
            got.payload = m_tdata[136:73];
            got.valid   = m_tuser[0];
            got.last    = m_tlast;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, key", got.key, '0);
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (got.status != want.status) begin
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                end
                if (got.count != want.count) begin
                    report_mismatch("entry_count", 64'(got.count), 64'(want.count));
                end
                if (got.key != want.key) report_mismatch("out_key", got.key, want.key);
                if (got.payload != want.payload) begin
                    report_mismatch("out_payload", got.payload, want.payload);
                end
                if (got.valid != want.valid) begin
                    report_mismatch("entry_valid", 64'(got.valid), 64'(want.valid));
                end
                if (got.last != want.last) begin
                    report_mismatch("last", 64'(got.last), 64'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles.", STALL_LIMIT);
            $display("keyed_sequential_list_table_unit verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        t_table_request req;
        int i;
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        held_count    = 0;
        hold_req      = 1'b0;
        error_count   = 0;
        stall_cycles  = 0;
        src_idle_pct  = 28;
        sink_idle_pct = 51;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            send_request(directed_rows[i]);
        end
        run_random(120);
        wait_for_drain();

        src_idle_pct  = 51;
        sink_idle_pct = 28;
        run_random(120);
        wait_for_drain();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (held_count < CAPACITY) send_request(fresh_insert());
        send_request(fresh_insert());
        send_request(fresh_insert());
        req = fresh_insert();
        req.key = held_keys[CAPACITY - 1];
        send_request(req);
        // The output side holds off while a full-table list is pending, so the
        // requests that follow back up against the input.
        hold_req = 1'b1;
        req = '0;
        req.func = FUNC_LIST;
        send_request(req);
        req.func = FUNC_REMOVE;
        req.key  = held_keys[CAPACITY / 2];
        send_request(req);
        send_request(fresh_insert());
        req.key = held_keys[0];
        send_request(req);
        req.func = FUNC_LIST;
        send_request(req);
        run_random(50);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts, %0d removes, %0d lists and %0d unused-code requests.",
                 requests_by_func[FUNC_INSERT], requests_by_func[FUNC_REMOVE],
                 requests_by_func[FUNC_LIST], requests_by_func[FUNC_UNUSED]);
        $display("Checked %0d results; the table peaked at %0d of %0d entries.",
                 results_checked, peak_count, CAPACITY);
        if (error_count == 0) begin
            $display("keyed_sequential_list_table_unit verification clean");
        end else begin
            $display("keyed_sequential_list_table_unit verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/kslt_pkg.sv
design/kslt_cell.sv
design/keyed_sequential_list_table_unit.sv
dv/keyed_sequential_list_table_unit_tb.sv
